### src/tnm_pkg.sv
// Shared types and constants for the timestamp nearest-match join.
package tnm_pkg;

    localparam int OFF_W   = 32;
    localparam int TIME_W  = 48;
    localparam int TOL_W   = 32;
    localparam int CNT_W   = 6;
    localparam int Q_DEPTH = 2;

    localparam logic [TOL_W-1:0] TOL_RESET = 32'd100;

    localparam logic [1:0] OP_LOAD_FIRST  = 2'd0;
    localparam logic [1:0] OP_LOAD_SECOND = 2'd1;
    localparam logic [1:0] OP_RUN         = 2'd2;

    typedef enum logic [1:0] {
        CMD_LOAD_FIRST,
        CMD_LOAD_SECOND,
        CMD_RUN
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_GAP,
        ST_DECIDE,
        ST_EMIT,
        ST_SUMMARY
    } t_state;

    typedef struct packed {
        logic [OFF_W-1:0]  offset;
        logic [TIME_W-1:0] time_ns;
    } t_rec;

    typedef struct packed {
        t_cmd cmd;
        t_rec rec;
    } t_entry;

endpackage

### src/tnm_in_if.sv
// Input channel: record loads and run commands.
interface tnm_in_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                opcode;
    logic [tnm_pkg::OFF_W-1:0]  record_offset;
    logic [tnm_pkg::TIME_W-1:0] record_time_ns;

    modport source (output valid, output opcode, output record_offset,
                    output record_time_ns, input ready);
    modport sink (input valid, input opcode, input record_offset,
                  input record_time_ns, output ready);
endinterface

### src/tnm_out_if.sv
// Output channel: matched pairs and the closing summary.
interface tnm_out_if;
    logic                       valid;
    logic                       ready;
    logic                       is_summary;
    logic [tnm_pkg::OFF_W-1:0]  first_offset;
    logic [tnm_pkg::TIME_W-1:0] first_time_ns;
    logic [tnm_pkg::OFF_W-1:0]  second_offset;
    logic [tnm_pkg::TIME_W-1:0] second_time_ns;
    logic [tnm_pkg::CNT_W-1:0]  match_count;
    logic                       overflow_flag;
    logic                       last_item;

    modport source (output valid, output is_summary, output first_offset,
                    output first_time_ns, output second_offset, output second_time_ns,
                    output match_count, output overflow_flag, output last_item,
                    input ready);
    modport sink (input valid, input is_summary, input first_offset,
                  input first_time_ns, input second_offset, input second_time_ns,
                  input match_count, input overflow_flag, input last_item,
                  output ready);
endinterface

### src/timestamp_nearest_match_join.sv
// Timestamp nearest-match join: loads two ascending lists of (offset, time) records of up
// to DEPTH entries each and, on a run command, merge-walks them with two pointers, emitting
// each pair whose time gap is within the tolerance (a strictly closer next second-list
// record is tried first), then a summary with the pair count and the overflow flag, after
// which both lists and the flag clear. Input transfers land in a two-entry command queue,
// so up to two commands are taken while a run is busy. The back end takes loads only when
// idle. In a run, each pointer step passes through the registered list read, the gap
// subtraction and the decision, each emitted pair adds an emit state, and the run ends
// with the final bounds check and the summary; emit and summary wait while the output
// side stalls. A run makes at most n1 + n2 pointer steps. The tolerance register resets
// to 100 ns and should be written only while the block is idle.
module timestamp_nearest_match_join #(
    parameter int DEPTH = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    tnm_in_if.sink                    i_in,
    tnm_out_if.source                 o_out,
    input  logic                      i_cfg_we,
    input  logic [tnm_pkg::TOL_W-1:0] i_cfg_wdata
);
    import tnm_pkg::*;

    logic [TOL_W-1:0] r_tol;
    t_entry           w_cmd;
    logic             w_cmd_valid;
    logic             w_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_wdata;
        end
    end

    tnm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd       (w_cmd),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_ready (w_cmd_ready)
    );

    tnm_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_ready (w_cmd_ready),
        .i_tol       (r_tol),
        .o_out       (o_out)
    );

endmodule

### src/tnm_front.sv
// Front end: accepts input transfers, decodes opcodes and queues commands.
module tnm_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    tnm_in_if.sink          i_in,
    output tnm_pkg::t_entry o_cmd,
    output logic            o_cmd_valid,
    input  logic            i_cmd_ready
);
    import tnm_pkg::*;

    t_entry     r_q [Q_DEPTH];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_keep;
    t_cmd       w_cmd;
    logic       w_push;
    logic       w_pop;

    // Unused opcodes are taken and dropped here; they never reach the back end.
    always_comb begin
        w_keep = 1'b1;
        w_cmd  = CMD_RUN;
        unique case (i_in.opcode)
            OP_LOAD_FIRST:  w_cmd = CMD_LOAD_FIRST;
            OP_LOAD_SECOND: w_cmd = CMD_LOAD_SECOND;
            OP_RUN:         w_cmd = CMD_RUN;
            default:        w_keep = 1'b0;
        endcase
    end

    assign i_in.ready  = (r_cnt != 2'(Q_DEPTH));
    assign w_push      = i_in.valid && i_in.ready && w_keep;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign w_pop       = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= '{cmd: w_cmd,
                           rec: '{offset: i_in.record_offset, time_ns: i_in.record_time_ns}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

### src/tnm_back.sv
// Back end: list storage, the two-pointer merge walk and the output register.
module tnm_back #(
    parameter int DEPTH = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  tnm_pkg::t_entry           i_cmd,
    input  logic                      i_cmd_valid,
    output logic                      o_cmd_ready,
    input  logic [tnm_pkg::TOL_W-1:0] i_tol,
    tnm_out_if.source                 o_out
);
    import tnm_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_rec r_mem_a [DEPTH];
    t_rec r_mem_b [DEPTH];

    t_state r_state;
    t_state n_state;

    logic [CNT_W-1:0]  r_cnt_a;
    logic [CNT_W-1:0]  r_cnt_b;
    logic              r_ovf;
    logic [CNT_W-1:0]  r_i;
    logic [CNT_W-1:0]  r_j;
    logic [CNT_W-1:0]  r_pairs;
    t_rec              r_rd_a;
    t_rec              r_rd_b0;
    t_rec              r_rd_b1;
    logic [TIME_W-1:0] r_gap;
    logic [TIME_W-1:0] r_gapn;
    logic              r_t1_lt;

    logic              r_o_valid;
    logic              r_o_summary;
    t_rec              r_o_first;
    t_rec              r_o_second;
    logic [CNT_W-1:0]  r_o_count;
    logic              r_o_ovf;
    logic              r_o_last;

    logic [CNT_W-1:0]  w_j1;
    logic              w_in_range;
    logic              w_match;
    logic              w_closer;
    logic              w_out_free;
    logic              w_wr_a;
    logic              w_wr_b;
    logic              w_set_ovf;
    logic              w_start;
    logic              w_inc_i;
    logic              w_inc_j;
    logic              w_load_pair;
    logic              w_load_sum;

    assign w_j1       = r_j + CNT_W'(1);
    assign w_in_range = (r_i < r_cnt_a) && (r_j < r_cnt_b);
    assign w_match    = (r_gap <= TIME_W'(i_tol));
    assign w_closer   = (w_j1 < r_cnt_b) && (r_gapn < r_gap);
    assign w_out_free = !r_o_valid || o_out.ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid && i_cmd.cmd == CMD_RUN) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = w_in_range ? ST_GAP : ST_SUMMARY;
            end
            ST_GAP: begin
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                n_state = (w_match && !w_closer) ? ST_EMIT : ST_READ;
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_state = ST_READ;
                end
            end
            ST_SUMMARY: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control outputs.
    always_comb begin
        o_cmd_ready = 1'b0;
        w_wr_a      = 1'b0;
        w_wr_b      = 1'b0;
        w_set_ovf   = 1'b0;
        w_start     = 1'b0;
        w_inc_i     = 1'b0;
        w_inc_j     = 1'b0;
        w_load_pair = 1'b0;
        w_load_sum  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    case (i_cmd.cmd)
                        CMD_LOAD_FIRST: begin
                            w_wr_a    = (r_cnt_a < CNT_W'(DEPTH));
                            w_set_ovf = !w_wr_a;
                        end
                        CMD_LOAD_SECOND: begin
                            w_wr_b    = (r_cnt_b < CNT_W'(DEPTH));
                            w_set_ovf = !w_wr_b;
                        end
                        CMD_RUN: w_start = 1'b1;
                        default: w_start = 1'b0;
                    endcase
                end
            end
            ST_DECIDE: begin
                // A strictly closer next second-list record takes precedence.
                if (w_match) begin
                    w_inc_j = w_closer;
                end else if (r_t1_lt) begin
                    w_inc_i = 1'b1;
                end else begin
                    w_inc_j = 1'b1;
                end
            end
            ST_EMIT: begin
                w_load_pair = w_out_free;
                w_inc_i     = w_out_free;
                w_inc_j     = w_out_free;
            end
            ST_SUMMARY: begin
                w_load_sum = w_out_free;
            end
            default: w_start = 1'b0;
        endcase
    end

    // List memories; read data is registered every cycle at the walk pointers.
    always_ff @(posedge i_clk) begin
        if (w_wr_a) begin
            r_mem_a[r_cnt_a[AW-1:0]] <= i_cmd.rec;
        end
        if (w_wr_b) begin
            r_mem_b[r_cnt_b[AW-1:0]] <= i_cmd.rec;
        end
        r_rd_a  <= r_mem_a[r_i[AW-1:0]];
        r_rd_b0 <= r_mem_b[r_j[AW-1:0]];
        r_rd_b1 <= r_mem_b[w_j1[AW-1:0]];
    end

    // Gap stage.
    always_ff @(posedge i_clk) begin
        r_gap   <= (r_rd_a.time_ns >= r_rd_b0.time_ns) ? (r_rd_a.time_ns - r_rd_b0.time_ns)
                                                       : (r_rd_b0.time_ns - r_rd_a.time_ns);
        r_gapn  <= (r_rd_a.time_ns >= r_rd_b1.time_ns) ? (r_rd_a.time_ns - r_rd_b1.time_ns)
                                                       : (r_rd_b1.time_ns - r_rd_a.time_ns);
        r_t1_lt <= (r_rd_a.time_ns < r_rd_b0.time_ns);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt_a   <= '0;
            r_cnt_b   <= '0;
            r_ovf     <= 1'b0;
            r_i       <= '0;
            r_j       <= '0;
            r_pairs   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_wr_a) begin
                r_cnt_a <= r_cnt_a + CNT_W'(1);
            end else if (w_load_sum) begin
                r_cnt_a <= '0;
            end
            if (w_wr_b) begin
                r_cnt_b <= r_cnt_b + CNT_W'(1);
            end else if (w_load_sum) begin
                r_cnt_b <= '0;
            end
            if (w_set_ovf) begin
                r_ovf <= 1'b1;
            end else if (w_load_sum) begin
                r_ovf <= 1'b0;
            end
            if (w_start) begin
                r_i     <= '0;
                r_j     <= '0;
                r_pairs <= '0;
            end else begin
                if (w_inc_i) begin
                    r_i <= r_i + CNT_W'(1);
                end
                if (w_inc_j) begin
                    r_j <= w_j1;
                end
                if (w_load_pair) begin
                    r_pairs <= r_pairs + CNT_W'(1);
                end
            end
            if (w_load_pair || w_load_sum) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_pair) begin
            r_o_summary <= 1'b0;
            r_o_first   <= r_rd_a;
            r_o_second  <= r_rd_b0;
            r_o_count   <= '0;
            r_o_ovf     <= 1'b0;
            r_o_last    <= 1'b0;
        end else if (w_load_sum) begin
            r_o_summary <= 1'b1;
            r_o_first   <= '0;
            r_o_second  <= '0;
            r_o_count   <= r_pairs;
            r_o_ovf     <= r_ovf;
            r_o_last    <= 1'b1;
        end
    end

    assign o_out.valid          = r_o_valid;
    assign o_out.is_summary     = r_o_summary;
    assign o_out.first_offset   = r_o_first.offset;
    assign o_out.first_time_ns  = r_o_first.time_ns;
    assign o_out.second_offset  = r_o_second.offset;
    assign o_out.second_time_ns = r_o_second.time_ns;
    assign o_out.match_count    = r_o_count;
    assign o_out.overflow_flag  = r_o_ovf;
    assign o_out.last_item      = r_o_last;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt_a <= CNT_W'(DEPTH)) && (r_cnt_b <= CNT_W'(DEPTH)))
        else $error("list count exceeds depth");

    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_GAP || r_state == ST_DECIDE || r_state == ST_EMIT)
        |-> (r_i < r_cnt_a) && (r_j < r_cnt_b))
        else $error("walk pointer beyond list end");

    a_pairs_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pairs <= r_i) && (r_pairs <= r_j))
        else $error("pair count exceeds pointer advance");

    a_clear_after_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_sum |=> (r_cnt_a == '0) && (r_cnt_b == '0) && !r_ovf && (r_state == ST_IDLE))
        else $error("lists not cleared after summary");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !o_out.ready) |-> !(w_load_pair || w_load_sum))
        else $error("output register overwritten while stalled");

endmodule

### tb/sv/timestamp_nearest_match_join_test.sv
// Self-checking testbench for the timestamp nearest-match join, with a cycle-free join predictor.
`timescale 1ns / 1ps

module timestamp_nearest_match_join_test;
    import tnm_pkg::*;

    localparam int          LIST_DEPTH     = 32;
    localparam logic [1:0]  OP_IGNORED     = 2'd3;
    localparam int          SETTLE_CYCLES  = 10;
    localparam int          END_CYCLES     = 250;
    localparam int          WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic              is_summary;
        logic [OFF_W-1:0]  first_offset;
        logic [TIME_W-1:0] first_time_ns;
        logic [OFF_W-1:0]  second_offset;
        logic [TIME_W-1:0] second_time_ns;
        logic [CNT_W-1:0]  match_count;
        logic              overflow_flag;
        logic              last_item;
    } t_join_result;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    logic [TOL_W-1:0]  cfg_wdata;

    tnm_in_if  cmd_ch ();
    tnm_out_if join_ch ();

    timestamp_nearest_match_join #(
        .DEPTH(LIST_DEPTH)
    ) uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (cmd_ch),
        .o_out      (join_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata)
    );

    always #10 clk = ~clk;

    // Predictor state: the two record lists, their fill levels and the drop flag.
    logic [OFF_W-1:0]  a_offset  [LIST_DEPTH];
    logic [TIME_W-1:0] a_time_ns [LIST_DEPTH];
    logic [OFF_W-1:0]  b_offset  [LIST_DEPTH];
    logic [TIME_W-1:0] b_time_ns [LIST_DEPTH];
    int                a_fill = 0;
    int                b_fill = 0;
    logic              load_dropped = 1'b0;
    logic [TOL_W-1:0]  tolerance_ns = TOL_RESET;

    t_join_result join_items_due [$];

    bit idling_on = 1'b1;
    int stall_left = 0;
    int quiet_cycles = 0;
    int mismatches = 0;
    int pairs_checked = 0;
    int summaries_checked = 0;
    int items_sent = 0;
    int runs_sent = 0;
    int settings_used = 1;

    function automatic logic [TIME_W-1:0] time_gap(input logic [TIME_W-1:0] x,
                                                   input logic [TIME_W-1:0] y);
        return (x >= y) ? x - y : y - x;
    endfunction

    function automatic logic [TIME_W-1:0] random_ns();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[TIME_W-1:0];
    endfunction

    function automatic logic [63:0] random_below(input logic [63:0] span);
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r % span;
    endfunction

    // Applies one accepted command to the predictor and queues the items it causes.
    task automatic predict_join_output(input logic [1:0] op, input logic [OFF_W-1:0] offset,
                                       input logic [TIME_W-1:0] stamp_ns);
        int                i;
        int                j;
        int                pairs;
        logic [TIME_W-1:0] t1;
        logic [TIME_W-1:0] t2;
        logic [TIME_W-1:0] gap;
        t_join_result      item;
        case (op)
            OP_LOAD_FIRST: begin
                if (a_fill < LIST_DEPTH) begin
                    a_offset[a_fill]  = offset;
                    a_time_ns[a_fill] = stamp_ns;
                    a_fill++;
                end else begin
                    load_dropped = 1'b1;
                end
            end
            OP_LOAD_SECOND: begin
                if (b_fill < LIST_DEPTH) begin
                    b_offset[b_fill]  = offset;
                    b_time_ns[b_fill] = stamp_ns;
                    b_fill++;
                end else begin
                    load_dropped = 1'b1;
                end
            end
            OP_RUN: begin
                i = 0;
                j = 0;
                pairs = 0;
                while (i < a_fill && j < b_fill) begin
                    t1  = a_time_ns[i];
                    t2  = b_time_ns[j];
                    gap = time_gap(t1, t2);
                    if (gap <= {{(TIME_W-TOL_W){1'b0}}, tolerance_ns}) begin
                        // A strictly closer next second-list record wins the first record.
                        if (j + 1 < b_fill && time_gap(t1, b_time_ns[j+1]) < gap) begin
                            j++;
                        end else begin
                            item = '0;
                            item.first_offset   = a_offset[i];
                            item.first_time_ns  = t1;
                            item.second_offset  = b_offset[j];
                            item.second_time_ns = t2;
                            join_items_due = {join_items_due, item};
                            pairs++;
                            i++;
                            j++;
                        end
                    end else if (t1 < t2) begin
                        i++;
                    end else begin
                        j++;
                    end
                end
                item = '0;
                item.is_summary    = 1'b1;
                item.match_count   = pairs[CNT_W-1:0];
                item.overflow_flag = load_dropped;
                item.last_item     = 1'b1;
                join_items_due = {join_items_due, item};
                a_fill = 0;
                b_fill = 0;
                load_dropped = 1'b0;
            end
            default: begin
            end
        endcase
    endtask

    // Entered and left at a falling edge; returns once the command transfer has happened.
    task automatic send_command(input logic [1:0] op, input logic [OFF_W-1:0] offset,
                                input logic [TIME_W-1:0] stamp_ns);
        if (idling_on && $urandom_range(0, 5) == 0) begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        cmd_ch.valid          <= 1'b1;
        cmd_ch.opcode         <= op;
        cmd_ch.record_offset  <= offset;
        cmd_ch.record_time_ns <= stamp_ns;
        @(posedge clk);
        while (!cmd_ch.ready) @(posedge clk);
        predict_join_output(op, offset, stamp_ns);
        if (op != OP_IGNORED) items_sent++;
        if (op == OP_RUN) runs_sent++;
        @(negedge clk);
    endtask

    task automatic wait_all_done();
        cmd_ch.valid <= 1'b0;
        while (join_items_due.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_tolerance(input logic [TOL_W-1:0] value);
        wait_all_done();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        tolerance_ns = value;
        settings_used++;
    endtask

    // Loads a batch of records into both lists and runs the join on it.
    task automatic play_join_sequence(input int unsigned n_events, input bit scrambled);
        logic [TIME_W-1:0] stamp;
        logic [TIME_W-1:0] step_ns;
        logic [TIME_W-1:0] jitter_ns;
        logic [63:0]       span;
        int unsigned       kind;
        span  = {32'd0, tolerance_ns} + 64'd1;
        stamp = random_ns();
        // Leave headroom so that well-formed lists do not wrap around.
        if (stamp > 48'hFF00_0000_0000) stamp = stamp - 48'h0100_0000_0000;
        for (int e = 0; e < n_events; e++) begin
            if ($urandom_range(0, 24) == 0) send_command(OP_IGNORED, $urandom, random_ns());
            step_ns   = TIME_W'(random_below(span + span));
            jitter_ns = TIME_W'(random_below(span + span / 2));
            stamp     = scrambled ? random_ns() : stamp + step_ns;
            kind      = $urandom_range(0, 2);
            if (kind != 1) send_command(OP_LOAD_FIRST, $urandom, stamp);
            if (kind == 1) send_command(OP_LOAD_SECOND, $urandom, stamp);
            if (kind == 2) begin
                stamp = stamp + jitter_ns;
                send_command(OP_LOAD_SECOND, $urandom, stamp);
            end
        end
        send_command(OP_RUN, $urandom, random_ns());
    endtask

    task automatic test_empty_lists();
        send_command(OP_RUN, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send_command(OP_LOAD_FIRST, 32'h1234_5678, 48'd500);
        send_command(OP_RUN, 32'h0, 48'h0);
        send_command(OP_LOAD_SECOND, 32'h8765_4321, 48'd500);
        send_command(OP_IGNORED, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send_command(OP_RUN, 32'h0, 48'h0);
    endtask

    task automatic test_closer_candidate();
        // The first record skips two candidates inside the tolerance for the closest one.
        send_command(OP_LOAD_FIRST, 32'hA000_0001, 48'd1000);
        send_command(OP_LOAD_SECOND, 32'hB000_0001, 48'd950);
        send_command(OP_LOAD_SECOND, 32'hB000_0002, 48'd990);
        send_command(OP_LOAD_SECOND, 32'hB000_0003, 48'd1005);
        send_command(OP_RUN, 32'h0, 48'h0);
        // Out of tolerance both ways: the earlier side advances each time until the last records pair up.
        send_command(OP_LOAD_FIRST, 32'hA000_0011, 48'd10);
        send_command(OP_LOAD_FIRST, 32'hA000_0012, 48'd700);
        send_command(OP_LOAD_SECOND, 32'hB000_0011, 48'd500);
        send_command(OP_LOAD_SECOND, 32'hB000_0012, 48'd690);
        send_command(OP_RUN, 32'h0, 48'h0);
    endtask

    task automatic test_field_extremes();
        write_tolerance(32'hFFFF_FFFF);
        send_command(OP_LOAD_FIRST, 32'h0000_0000, 48'h0);
        send_command(OP_LOAD_FIRST, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send_command(OP_LOAD_SECOND, 32'hFFFF_FFFF, 48'h0000_FFFF_FFFF);
        send_command(OP_LOAD_SECOND, 32'h0000_0000, 48'hFFFF_FFFF_FFFF);
        send_command(OP_RUN, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        // With zero tolerance only equal times pair up.
        write_tolerance(32'h0);
        send_command(OP_LOAD_FIRST, 32'h5555_5555, 48'd5);
        send_command(OP_LOAD_FIRST, 32'hAAAA_AAAA, 48'd6);
        send_command(OP_LOAD_SECOND, 32'h5A5A_5A5A, 48'd5);
        send_command(OP_LOAD_SECOND, 32'hA5A5_A5A5, 48'd7);
        send_command(OP_RUN, 32'h0, 48'h0);
    endtask

    task automatic test_random_joins(input logic [TOL_W-1:0] tol, input int quota);
        int goal;
        write_tolerance(tol);
        goal = items_sent + quota;
        while (items_sent < goal) begin
            case ($urandom_range(0, 9))
                0: play_join_sequence($urandom_range(30, 40), 1'b0);
                1: play_join_sequence($urandom_range(0, 6), 1'b1);
                default: play_join_sequence($urandom_range(0, 10), 1'b0);
            endcase
        end
    endtask

    task automatic test_full_lists();
        logic [TIME_W-1:0] stamp;
        logic [TIME_W-1:0] step_ns;
        write_tolerance(32'hFFFF_FFFF);
        stamp = random_ns() & 48'h7FFF_FFFF_FFFF;
        // Both lists overfill; every kept record pairs with its neighbor in the other list.
        for (int e = 0; e < LIST_DEPTH + 2; e++) begin
            step_ns = TIME_W'(random_below(64'd1000));
            send_command(OP_LOAD_FIRST, $urandom, stamp);
            send_command(OP_LOAD_SECOND, $urandom, stamp + step_ns);
            stamp = stamp + 48'h4_0000_0000 + TIME_W'(32'(random_ns()));
        end
        send_command(OP_RUN, $urandom, random_ns());
        // The drop flag must have cleared with the run.
        send_command(OP_RUN, $urandom, random_ns());
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk) begin : check_join_items
        t_join_result want;
        if (rst_n && join_ch.valid && join_ch.ready) begin
            if (join_items_due.size() == 0) begin
                $error("Output transfer with nothing expected (is_summary %0b, count %0d)",
                       join_ch.is_summary, join_ch.match_count);
                mismatches++;
            end else begin
                want = join_items_due.pop_front();
                compare_field("is_summary", 64'(want.is_summary), 64'(join_ch.is_summary));
                compare_field("first_offset", 64'(want.first_offset),
                              64'(join_ch.first_offset));
                compare_field("first_time_ns", 64'(want.first_time_ns),
                              64'(join_ch.first_time_ns));
                compare_field("second_offset", 64'(want.second_offset),
                              64'(join_ch.second_offset));
                compare_field("second_time_ns", 64'(want.second_time_ns),
                              64'(join_ch.second_time_ns));
                compare_field("match_count", 64'(want.match_count), 64'(join_ch.match_count));
                compare_field("overflow_flag", 64'(want.overflow_flag),
                              64'(join_ch.overflow_flag));
                compare_field("last_item", 64'(want.last_item), 64'(join_ch.last_item));
                if (want.is_summary) summaries_checked++;
                else pairs_checked++;
            end
        end
    end

    always @(negedge clk) begin
        if (stall_left > 0) begin
            join_ch.ready <= 1'b0;
            stall_left--;
        end else if (idling_on && $urandom_range(0, 6) == 0) begin
            join_ch.ready <= 1'b0;
            stall_left = $urandom_range(0, 4);
        end else begin
            join_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (join_ch.valid && join_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles, %0d items still expected",
                     WATCHDOG_LIMIT, join_items_due.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_wdata             = '0;
        cmd_ch.valid          = 1'b0;
        cmd_ch.opcode         = OP_LOAD_FIRST;
        cmd_ch.record_offset  = '0;
        cmd_ch.record_time_ns = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_lists();
        test_closer_candidate();
        test_field_extremes();
        test_random_joins(32'd100, 110);
        test_random_joins($urandom_range(0, 1000), 110);
        test_random_joins(32'd0, 60);
        test_random_joins(32'hFFFF_FFFF, 60);
        test_full_lists();
        test_random_joins($urandom, 50);
        idling_on = 1'b0;
        test_random_joins($urandom_range(0, 5000), 60);

        wait_all_done();
        repeat (END_CYCLES) @(negedge clk);
        $display("Sent %0d commands (%0d runs) under %0d tolerance settings.",
                 items_sent, runs_sent, settings_used);
        $display("Checked %0d matched pairs and %0d summaries, %0d mismatches.",
                 pairs_checked, summaries_checked, mismatches);
        if (mismatches == 0 && join_items_due.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
